[hdl/mean_squared_error_loss_macros.svh]
// Assertion macros shared by the mean squared error loss RTL.
`ifndef MEAN_SQUARED_ERROR_LOSS_MACROS_SVH
`define MEAN_SQUARED_ERROR_LOSS_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define MSE_ASSERT_NOW(name, clk, rst, pre, post, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define MSE_ASSERT_NEXT(name, clk, rst, pre, post, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

[hdl/mse_pkg.sv]
// Shared types and constants for the mean squared error loss block.
package mse_pkg;

   localparam int SMP_W          = 16;  // Q4.12 sample
   localparam int DIFF_W         = SMP_W + 1;
   localparam int MAG_W          = SMP_W;  // |diff| never exceeds 65535
   localparam int SQ_W           = 2 * MAG_W;
   localparam int SUM_W          = 44;
   localparam int MEAN_W         = 32;
   localparam int MAX_ELEMENTS_DEF = 4096;

   localparam int QUEUE_DEPTH    = 4;
   localparam int QPTR_W         = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W         = $clog2(QUEUE_DEPTH + 1);

   localparam logic [MEAN_W-1:0] MEAN_LIMIT = 32'hFFFE_0001;  // 65535^2

   typedef struct packed {
      logic [QCNT_W-1:0] fill;
      logic              empty;
   } q_status_type;

endpackage

[hdl/mse_front.sv]
// Front end: takes sample words, squares differences, accumulates per vector.
module mse_front
   import mse_pkg::*;
#(
   parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF,
   parameter int CNT_W        = $clog2(MAX_ELEMENTS + 1)
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic signed [SMP_W-1:0]  req_pred_value,
   input  logic signed [SMP_W-1:0]  req_target_value,
   input  logic                     req_last_element,
   input  q_status_type             q_status,
   output logic                     q_push,
   output logic [SUM_W-1:0]         q_sum,
   output logic [CNT_W-1:0]         q_count,
   output logic                     q_ovf
);

   logic              v1_ff, v1_in, last1_ff, last1_in;
   logic [MAG_W-1:0]  mag1_ff, mag1_in;
   logic              v2_ff, v2_in, last2_ff, last2_in;
   logic [SQ_W-1:0]   sq2_ff, sq2_in;
   logic [SUM_W-1:0]  sum_ff, sum_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              ovf_ff, ovf_in;

   logic signed [DIFF_W-1:0] diff;
   logic [DIFF_W-1:0]        diff_abs;
   logic [QCNT_W:0]          committed;
   logic                     accept;
   logic [SUM_W:0]           sum_wide;
   logic [SUM_W-1:0]         sum_acc;
   logic [CNT_W-1:0]         cnt_acc;
   logic                     ovf_acc;
   logic                     full;

   // a last word in flight already owns a queue slot
   assign committed = {1'b0, q_status.fill}
                    + (QCNT_W+1)'(v1_ff & last1_ff)
                    + (QCNT_W+1)'(v2_ff & last2_ff);
   assign req_ready = committed < (QCNT_W+1)'(QUEUE_DEPTH);
   assign accept    = req_valid & req_ready;

   assign diff     = DIFF_W'(req_pred_value) - DIFF_W'(req_target_value);
   assign diff_abs = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);

   assign v1_in    = accept;
   assign last1_in = req_last_element;
   assign mag1_in  = diff_abs[MAG_W-1:0];

   assign v2_in    = v1_ff;
   assign last2_in = last1_ff;
   assign sq2_in   = mag1_ff * mag1_ff;

   // accumulate stage
   assign full     = cnt_ff == CNT_W'(MAX_ELEMENTS);
   assign sum_wide = {1'b0, sum_ff} + (SUM_W+1)'(sq2_ff);

   always_comb begin
      sum_acc = sum_ff;
      cnt_acc = cnt_ff;
      ovf_acc = ovf_ff;
      if (v2_ff) begin
         if (full) begin
            ovf_acc = 1'b1;
         end else begin
            sum_acc = sum_wide[SUM_W] ? {SUM_W{1'b1}} : sum_wide[SUM_W-1:0];
            cnt_acc = cnt_ff + CNT_W'(1);
         end
      end
   end

   assign q_push  = v2_ff & last2_ff;
   assign q_sum   = sum_acc;
   assign q_count = cnt_acc;
   assign q_ovf   = ovf_acc;

   assign sum_in = q_push ? '0 : sum_acc;
   assign cnt_in = q_push ? '0 : cnt_acc;
   assign ovf_in = q_push ? 1'b0 : ovf_acc;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff  <= 1'b0;
         v2_ff  <= 1'b0;
         sum_ff <= '0;
         cnt_ff <= '0;
         ovf_ff <= 1'b0;
      end else begin
         v1_ff  <= v1_in;
         v2_ff  <= v2_in;
         sum_ff <= sum_in;
         cnt_ff <= cnt_in;
         ovf_ff <= ovf_in;
      end
      last1_ff <= last1_in;
      mag1_ff  <= mag1_in;
      last2_ff <= last2_in;
      sq2_ff   <= sq2_in;
   end

endmodule

[hdl/mse_queue.sv]
// Short queue of finished vector totals between front and back.
module mse_queue
   import mse_pkg::*;
#(
   parameter int DATA_W = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  logic [DATA_W-1:0] push_data,
   input  logic              pop,
   output logic [DATA_W-1:0] pop_data,
   output q_status_type      status
);

   logic [DATA_W-1:0] slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [QCNT_W-1:0] fill_ff, fill_in;

   assign wr_in   = push ? wr_ff + QPTR_W'(1) : wr_ff;
   assign rd_in   = pop  ? rd_ff + QPTR_W'(1) : rd_ff;
   assign fill_in = fill_ff + QCNT_W'(push) - QCNT_W'(pop);

   assign pop_data     = slot_ff[rd_ff];
   assign status.fill  = fill_ff;
   assign status.empty = fill_ff == '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff   <= '0;
         rd_ff   <= '0;
         fill_ff <= '0;
      end else begin
         wr_ff   <= wr_in;
         rd_ff   <= rd_in;
         fill_ff <= fill_in;
      end
      if (push) begin
         slot_ff[wr_ff] <= push_data;
      end
   end

endmodule

[hdl/mse_back.sv]
// Back end: bit-serial division of the vector sum by its count.
module mse_back
   import mse_pkg::*;
#(
   parameter int CNT_W = $clog2(MAX_ELEMENTS_DEF + 1)
) (
   input  logic              clock,
   input  logic              reset,
   input  q_status_type      q_status,
   output logic              q_pop,
   input  logic [SUM_W-1:0]  q_sum,
   input  logic [CNT_W-1:0]  q_count,
   input  logic              q_ovf,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [MEAN_W-1:0] rsp_mean_loss,
   output logic              rsp_element_overflow
);

   localparam int STEP_W = $clog2(SUM_W);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DONE
   } state_type;

   state_type         state_ff;
   logic [SUM_W-1:0]  quo_ff;
   logic [CNT_W-1:0]  rem_ff, div_ff;
   logic [STEP_W-1:0] step_ff;
   logic              ovf_ff, zero_ff;
   logic              rsp_valid_ff;
   logic [MEAN_W-1:0] rsp_mean_ff;
   logic              rsp_ovf_ff;

   logic [CNT_W:0]    trial;
   logic              take;
   logic [CNT_W:0]    trial_sub;
   logic [CNT_W-1:0]  rem_in;
   logic [SUM_W-1:0]  quo_in;
   logic              out_free;
   logic              load_rsp;
   logic [MEAN_W-1:0] mean_sat;

   assign q_pop = (state_ff == ST_IDLE) & ~q_status.empty;

   // one restoring step per cycle
   assign trial     = {rem_ff, quo_ff[SUM_W-1]};
   assign take      = trial >= {1'b0, div_ff};
   assign trial_sub = trial - {1'b0, div_ff};
   assign rem_in    = take ? trial_sub[CNT_W-1:0] : trial[CNT_W-1:0];
   assign quo_in    = {quo_ff[SUM_W-2:0], take};

   assign out_free  = ~rsp_valid_ff | rsp_ready;
   assign load_rsp  = (state_ff == ST_DONE) & out_free;

   always_comb begin
      if (zero_ff) begin
         mean_sat = '0;
      end else if (|quo_ff[SUM_W-1:MEAN_W]) begin
         mean_sat = {MEAN_W{1'b1}};
      end else begin
         mean_sat = quo_ff[MEAN_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (q_pop) begin
                  quo_ff   <= q_sum;
                  div_ff   <= q_count;
                  rem_ff   <= '0;
                  step_ff  <= '0;
                  ovf_ff   <= q_ovf;
                  zero_ff  <= q_count == '0;
                  state_ff <= ST_RUN;
               end
            end
            ST_RUN: begin
               quo_ff  <= quo_in;
               rem_ff  <= rem_in;
               step_ff <= step_ff + STEP_W'(1);
               if (step_ff == STEP_W'(SUM_W - 1)) begin
                  state_ff <= ST_DONE;
               end
            end
            ST_DONE: begin
               if (load_rsp) begin
                  rsp_mean_ff  <= mean_sat;
                  rsp_ovf_ff   <= ovf_ff;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_mean_loss        = rsp_mean_ff;
   assign rsp_element_overflow = rsp_ovf_ff;

endmodule

[hdl/mean_squared_error_loss.sv]
// Throughput: one sample word per cycle while req_ready is high. The bit-serial
//   divider works on one vector total at a time, one quotient bit per cycle over
//   44 bits.
// A four-entry queue holds vector totals, so new vectors stream while one divides;
//   input stalls once four totals are queued or in flight. Reset (synchronous,
//   active high) clears sum, count, flag, queue and divider.
`include "mean_squared_error_loss_macros.svh"

module mean_squared_error_loss
   import mse_pkg::*;
#(
   parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic signed [SMP_W-1:0] req_pred_value,
   input  logic signed [SMP_W-1:0] req_target_value,
   input  logic                    req_last_element,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [MEAN_W-1:0]       rsp_mean_loss,
   output logic                    rsp_element_overflow
);

   // count must reach MAX_ELEMENTS itself
   localparam int CNT_W  = $clog2(MAX_ELEMENTS + 1);
   localparam int ENT_W  = SUM_W + CNT_W + 1;

   q_status_type     q_status;
   logic             q_push, q_pop;
   logic [SUM_W-1:0] f_sum, b_sum;
   logic [CNT_W-1:0] f_count, b_count;
   logic             f_ovf, b_ovf;

   // front: subtract, square, accumulate; pushes one total per vector
   mse_front #(
      .MAX_ELEMENTS (MAX_ELEMENTS),
      .CNT_W        (CNT_W)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_pred_value   (req_pred_value),
      .req_target_value (req_target_value),
      .req_last_element (req_last_element),
      .q_status         (q_status),
      .q_push           (q_push),
      .q_sum            (f_sum),
      .q_count          (f_count),
      .q_ovf            (f_ovf)
   );

   // totals waiting for the divider
   mse_queue #(
      .DATA_W (ENT_W)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data ({f_sum, f_count, f_ovf}),
      .pop       (q_pop),
      .pop_data  ({b_sum, b_count, b_ovf}),
      .status    (q_status)
   );

   // back: sum / count, registered result word
   mse_back #(
      .CNT_W (CNT_W)
   ) u_back (
      .clock                (clock),
      .reset                (reset),
      .q_status             (q_status),
      .q_pop                (q_pop),
      .q_sum                (b_sum),
      .q_count              (b_count),
      .q_ovf                (b_ovf),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_mean_loss        (rsp_mean_loss),
      .rsp_element_overflow (rsp_element_overflow)
   );

   `MSE_ASSERT_NOW(a_fill_bound, clock, reset, 1'b1,
      q_status.fill <= QCNT_W'(QUEUE_DEPTH), "queue fill beyond depth")
   `MSE_ASSERT_NOW(a_push_room, clock, reset, q_push && !q_pop,
      q_status.fill < QCNT_W'(QUEUE_DEPTH), "push into full queue")
   `MSE_ASSERT_NOW(a_pop_data, clock, reset, q_pop, !q_status.empty, "pop from empty queue")
   `MSE_ASSERT_NOW(a_mean_limit, clock, reset, rsp_valid,
      rsp_mean_loss <= MEAN_LIMIT, "mean above largest square")
   `MSE_ASSERT_NEXT(a_fill_step, clock, reset, q_push && !q_pop,
      q_status.fill == $past(q_status.fill) + QCNT_W'(1), "queue fill did not advance")

endmodule

[tb/mean_squared_error_loss_test.sv]
// Self-checking testbench for the mean squared error loss block.
`timescale 1ns / 1ps

// Scoreboard: tracks the running vector totals and holds the expected mean words.
class mse_scoreboard;
   typedef struct {
      logic [mse_pkg::MEAN_W-1:0] mean;
      logic                       dropped;
   } mean_word_type;

   localparam longint unsigned SUM_CAP  = (64'd1 << mse_pkg::SUM_W) - 64'd1;
   localparam longint unsigned MEAN_CAP = 64'hFFFF_FFFF;

   mean_word_type   mean_q[$];
   longint unsigned sq_sum;
   int unsigned     pair_count;
   bit              pairs_dropped;
   int unsigned     mismatches;
   int unsigned     words_noted;
   int unsigned     vectors_noted;
   int unsigned     vectors_clipped;
   int unsigned     means_checked;

   function new();
      sq_sum          = 0;
      pair_count      = 0;
      pairs_dropped   = 0;
      mismatches      = 0;
      words_noted     = 0;
      vectors_noted   = 0;
      vectors_clipped = 0;
      means_checked   = 0;
   endfunction

   // Fold one accepted sample word into the totals; close the vector on last.
   function void note_word(logic signed [mse_pkg::SMP_W-1:0] pred,
                           logic signed [mse_pkg::SMP_W-1:0] tgt,
                           logic last);
      int              diff;
      longint unsigned sq;
      longint unsigned mean;
      mean_word_type   w;
      diff = int'(pred) - int'(tgt);
      if (diff < 0)
         diff = -diff;
      sq = longint'(diff);
      sq = sq * sq;
      words_noted++;
      if (pair_count >= mse_pkg::MAX_ELEMENTS_DEF) begin
         pairs_dropped = 1'b1;
      end else begin
         sq_sum += sq;
         if (sq_sum > SUM_CAP)
            sq_sum = SUM_CAP;
         pair_count++;
      end
      if (!last)
         return;
      mean = (pair_count != 0) ? sq_sum / longint'(pair_count) : 64'd0;
      if (mean > MEAN_CAP)
         mean = MEAN_CAP;
      w.mean    = mean[mse_pkg::MEAN_W-1:0];
      w.dropped = pairs_dropped;
      mean_q.push_back(w);
      vectors_noted++;
      if (pairs_dropped)
         vectors_clipped++;
      sq_sum        = 0;
      pair_count    = 0;
      pairs_dropped = 1'b0;
   endfunction

   task report(string what);
      $display("MISMATCH: %s", what);
      mismatches++;
   endtask

   task check_mean(logic [mse_pkg::MEAN_W-1:0] mean, logic dropped);
      mean_word_type w;
      if (mean_q.size() == 0) begin
         report($sformatf("result word with nothing pending: mean %h overflow %b",
                          mean, dropped));
         return;
      end
      w = mean_q.pop_front();
      means_checked++;
      if (mean !== w.mean)
         report($sformatf("result %0d mean_loss got %h want %h", means_checked, mean, w.mean));
      if (dropped !== w.dropped)
         report($sformatf("result %0d element_overflow got %b want %b", means_checked,
                          dropped, w.dropped));
   endtask
endclass

module mean_squared_error_loss_test
   import mse_pkg::*;
;

   localparam int unsigned LIMIT_NS     = 8_000_000;  // watchdog bound, clock period 8 ns
   localparam int unsigned RANDOM_WORDS = 1200;
   localparam int unsigned HOLD_CYCLES  = 400;      // long receiver stall
   localparam int unsigned HOLD_AT      = 12;       // after this many results
   localparam int unsigned TAIL_CYCLES  = 80;       // > divider latency

   logic                    clock;
   logic                    reset;
   logic                    req_valid;
   logic                    req_ready;
   logic signed [SMP_W-1:0] req_pred_value;
   logic signed [SMP_W-1:0] req_target_value;
   logic                    req_last_element;
   logic                    rsp_valid;
   logic                    rsp_ready;
   logic [MEAN_W-1:0]       rsp_mean_loss;
   logic                    rsp_element_overflow;

   mse_scoreboard sb = new();

   // Idle-free stretches: each side flips in and out of steady mode at random.
   bit sender_steady   = 1'b0;
   bit receiver_steady = 1'b0;

   mean_squared_error_loss dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_pred_value      (req_pred_value),
      .req_target_value    (req_target_value),
      .req_last_element    (req_last_element),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_mean_loss       (rsp_mean_loss),
      .rsp_element_overflow(rsp_element_overflow)
   );

   initial clock = 1'b0;
   always #4 clock = ~clock;

   // Sample value: extremes and small values often, otherwise full range.
   function automatic logic signed [SMP_W-1:0] draw_sample();
      case ($urandom_range(0, 7))
         0:       return 16'sh7FFF;
         1:       return 16'sh8000;
         2:       return '0;
         3:       return 16'(int'($urandom_range(0, 16)) - 8);
         default: return 16'($urandom());
      endcase
   endfunction

   // Offer one sample word after a random gap; returns at the edge that takes it.
   // Handshake is sampled at the falling edge, where it already holds the value
   // the next rising edge will see.
   task automatic send_word(input logic signed [SMP_W-1:0] pred,
                            input logic signed [SMP_W-1:0] tgt,
                            input logic last);
      int unsigned gap;
      bit          took;
      gap = sender_steady ? 0 : $urandom_range(0, 6);
      if ($urandom_range(0, 99) == 0)
         sender_steady = !sender_steady;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_pred_value   <= pred;
      req_target_value <= tgt;
      req_last_element <= last;
      do begin
         @(negedge clock);
         took = req_ready;
         @(posedge clock);
      end while (!took);
      sb.note_word(pred, tgt, last);
   endtask

   // One vector of random samples; target sometimes tracks the prediction closely.
   task automatic send_random_vector(input int unsigned len);
      logic signed [SMP_W-1:0] p;
      logic signed [SMP_W-1:0] t;
      for (int unsigned n = 0; n < len; n++) begin
         p = draw_sample();
         t = ($urandom_range(0, 5) == 0) ? p + 16'(int'($urandom_range(0, 4)) - 2)
                                         : draw_sample();
         send_word(p, t, n == len - 1);
      end
   endtask

   // Stimulus: directed vectors, then random vectors.
   initial begin
      int unsigned random_sent;
      int unsigned len;
      int unsigned pick;
      reset            <= 1'b1;
      req_valid        <= 1'b0;
      req_pred_value   <= '0;
      req_target_value <= '0;
      req_last_element <= 1'b0;
      rsp_ready        <= 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // single-word vectors at the largest difference, both signs -> 0xFFFE0001
      send_word(16'sh7FFF, 16'sh8000, 1'b1);
      send_word(16'sh8000, 16'sh7FFF, 1'b1);
      // zero difference, at zero and at -1
      send_word(16'sh0000, 16'sh0000, 1'b1);
      send_word(16'shFFFF, 16'shFFFF, 1'b1);
      // 1 + 4 over 2: truncated division
      send_word(16'sh0001, 16'sh0000, 1'b0);
      send_word(16'sh0000, 16'sh0002, 1'b1);
      // mixed three-word vector
      send_word(16'sh0064, -16'sh0064, 1'b0);
      send_word(-16'sh0005, 16'sh0007, 1'b0);
      send_word(16'sh7FFF, 16'sh7FFF, 1'b1);
      // totals must be clear again after a multi-word vector
      send_word(16'sh0002, 16'sh0000, 1'b1);

      // random vectors, mostly short so results keep coming
      random_sent = 0;
      while (random_sent < RANDOM_WORDS) begin
         pick = $urandom_range(0, 19);
         if (pick < 14)
            len = $urandom_range(1, 6);
         else if (pick < 19)
            len = $urandom_range(7, 40);
         else
            len = $urandom_range(41, 300);
         send_random_vector(len);
         random_sent += len;
      end
      req_valid <= 1'b0;

      // drain, then watch a while for stray result words
      while (sb.mean_q.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("covered %0d sample words in %0d vectors, %0d past the element limit",
               sb.words_noted, sb.vectors_noted, sb.vectors_clipped);
      $display("checked %0d mean words, %0d mismatches", sb.means_checked, sb.mismatches);
      if (sb.mismatches == 0)
         $display("mean_squared_error_loss_test: clean");
      else
         $display("mean_squared_error_loss_test: errors");
      $finish;
   end

   // Result side: random ready gaps, plus one long hold-off so the total queue
   // fills and the block has to stall its input.
   initial begin
      int unsigned gap;
      int unsigned taken;
      bit          took;
      bit          held;
      logic [MEAN_W-1:0] mean;
      logic              dropped;
      taken = 0;
      held  = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (!held && taken == HOLD_AT) begin
            held = 1'b1;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            gap = receiver_steady ? 0 : $urandom_range(0, 6);
            if ($urandom_range(0, 49) == 0)
               receiver_steady = !receiver_steady;
            if (gap != 0) begin
               rsp_ready <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
         rsp_ready <= 1'b1;
         do begin
            @(negedge clock);
            took    = rsp_valid;
            mean    = rsp_mean_loss;
            dropped = rsp_element_overflow;
            @(posedge clock);
         end while (!took);
         sb.check_mean(mean, dropped);
         taken++;
      end
   end

   // Watchdog: generous bound over the slowest legal run.
   initial begin
      #(LIMIT_NS);
      $display("mean_squared_error_loss_test: errors");
      $finish;
   end

endmodule

[sim.f]
+incdir+hdl
hdl/mse_pkg.sv
hdl/mse_front.sv
hdl/mse_queue.sv
hdl/mse_back.sv
hdl/mean_squared_error_loss.sv
tb/mean_squared_error_loss_test.sv
